### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SVM_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define SVM_ASSERT_NEVER(lbl, ck, rs, expr, msg) \
  `SVM_ASSERT(lbl, ck, rs, !(expr), msg)
`else
`define SVM_ASSERT(lbl, ck, rs, prop, msg)
`define SVM_ASSERT_NEVER(lbl, ck, rs, expr, msg)
`endif
`endif

### hw/rtl/svm_pkg.sv
// ---------------------------------------------------------------------------
// svm_pkg
// Sizes, opcodes, status codes, controller states and shared helpers.
// ---------------------------------------------------------------------------
`default_nettype none
package svm_pkg;
  localparam int MEM_WORDS   = 32768;
  localparam int STACK_DEPTH = 256;
  localparam int NUM_REGS    = 8;
  localparam int MEM_AW      = $clog2(MEM_WORDS);
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int SP_W        = STK_AW + 1;
  localparam int REG_AW      = $clog2(NUM_REGS);
  localparam logic [15:0] OP_LAST = 16'h15;

  typedef enum logic [4:0] {
    OP_HALT, OP_SET, OP_PUSH, OP_POP, OP_EQ, OP_GT, OP_JMP, OP_JT, OP_JF,
    OP_ADD, OP_MULT, OP_MOD, OP_AND, OP_OR, OP_NOT, OP_RMEM, OP_WMEM,
    OP_CALL, OP_RET, OP_OUT, OP_IN, OP_NOOP
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK, STAT_HALT, STAT_EMPTY, STAT_BADOP, STAT_OVFL, STAT_DIV0, STAT_BADARG
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_F0, S_F1, S_F2, S_F3, S_F4, S_EVAL, S_DIV, S_COMMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       take;
    logic       clear;
    logic       fetch;
    logic [1:0] fetch_idx;
    logic       cap;
    logic [1:0] cap_idx;
    logic       rd_issue;
    logic       div_start;
    logic       commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic run;
    logic need_mem;
    logic need_stk;
    logic need_div;
    logic div_busy;
    logic out_free;
  } sts_t;

  function automatic logic [2:0] op_count(input op_t op);
    logic [2:0] n;
    unique case (op)
      OP_HALT, OP_RET, OP_NOOP:                          n = 3'd0;
      OP_PUSH, OP_POP, OP_JMP, OP_CALL, OP_OUT, OP_IN:    n = 3'd1;
      OP_SET, OP_JT, OP_JF, OP_NOT, OP_RMEM, OP_WMEM:     n = 3'd2;
      default:                                           n = 3'd3;
    endcase
    return n;
  endfunction

  function automatic logic addr_ok(input logic [15:0] v);
    return 32'(v) < MEM_WORDS;
  endfunction

  function automatic logic is_reg(input logic [15:0] w);
    return w[15] && (32'(w[14:0]) < NUM_REGS);
  endfunction
endpackage
`default_nettype wire

### hw/rtl/svm_div.sv
// ---------------------------------------------------------------------------
// svm_div
// Restoring 16-bit divider, one quotient bit per cycle, remainder only.
// ---------------------------------------------------------------------------
`default_nettype none
module svm_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             busy,
  output logic [15:0]      rem
);
  logic [15:0] dvd;
  logic [15:0] dvs;
  logic [4:0]  cnt;
  logic [16:0] trial;
  logic [16:0] diff;

  // shift in next dividend bit, subtract when it fits
  assign trial = {rem, dvd[15]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd16;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= diff[16] ? trial[15:0] : diff[15:0];
      dvd <= {dvd[14:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

### hw/rtl/svm_dpath.sv
// ---------------------------------------------------------------------------
// svm_dpath
// Program memory, register file, stack, decode/execute and result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module svm_dpath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tuser,
  input  wire logic [39:0]   s_tdata,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [31:0]        m_tdata,
  input  wire svm_pkg::cmd_t cmd,
  output svm_pkg::sts_t      sts
);
  localparam int AW  = svm_pkg::MEM_AW;
  localparam int SPW = svm_pkg::SP_W;
  localparam int SAW = svm_pkg::STK_AW;

  // state
  logic [15:0] mem [svm_pkg::MEM_WORDS];
  logic [15:0] stack [svm_pkg::STACK_DEPTH];
  logic [15:0] regs [svm_pkg::NUM_REGS];
  logic [AW-1:0]  pc;
  logic [SPW-1:0] sp;
  svm_pkg::status_t stopped;
  logic [AW:0]    clr_cnt;

  // latched item and fetched words
  logic        kind;
  logic [14:0] laddr;
  logic [15:0] lword;
  logic [7:0]  ch;
  logic [15:0] w [4];
  logic [15:0] mem_rdata;
  logic [15:0] stk_rdata;

  // result register
  svm_pkg::status_t r_status;
  logic        r_out_valid;
  logic [7:0]  r_out_char;
  logic        r_in_used;
  logic [14:0] r_next_pc;

  logic [15:0] div_rem;
  logic        div_busy;

  logic run, out_free, sp_full, sp_empty;
  logic op_bad;
  svm_pkg::op_t op;
  logic [15:0] v1, v2, v3;
  logic ok1, ok2, ok3, d1ok;
  logic [AW:0] npc_sum, fsum;
  logic [AW-1:0] npc, new_pc, faddr;
  logic [16:0] add_sum;
  logic [31:0] prod;
  logic [SPW-1:0] sp_m1;

  svm_pkg::status_t err;
  logic reg_we, push, pop, mem_wr, out_v, in_u, take;
  logic need_mem, need_stk, need_div;
  logic [15:0] reg_wd, push_d;

  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0] mem_wdata;
  logic load_wr, exec_ok;

  assign run      = kind && (stopped == svm_pkg::STAT_OK);
  assign out_free = !m_tvalid || m_tready;
  assign sp_full  = sp >= SPW'(svm_pkg::STACK_DEPTH);
  assign sp_empty = sp == '0;
  assign sp_m1    = sp - SPW'(1);

  // operand resolution
  always_comb begin
    op_bad = w[0] > svm_pkg::OP_LAST;
    op     = svm_pkg::op_t'(w[0][4:0]);
    v1     = w[1][15] ? regs[w[1][svm_pkg::REG_AW-1:0]] : w[1];
    v2     = w[2][15] ? regs[w[2][svm_pkg::REG_AW-1:0]] : w[2];
    v3     = w[3][15] ? regs[w[3][svm_pkg::REG_AW-1:0]] : w[3];
    ok1    = !w[1][15] || svm_pkg::is_reg(w[1]);
    ok2    = !w[2][15] || svm_pkg::is_reg(w[2]);
    ok3    = !w[3][15] || svm_pkg::is_reg(w[3]);
    d1ok   = svm_pkg::is_reg(w[1]);
  end

  // next pc and fetch address, both wrap at the memory size
  always_comb begin
    npc_sum = {1'b0, pc} + (AW+1)'(svm_pkg::op_count(op)) + (AW+1)'(1);
    npc = (npc_sum >= (AW+1)'(svm_pkg::MEM_WORDS))
        ? AW'(npc_sum - (AW+1)'(svm_pkg::MEM_WORDS)) : AW'(npc_sum);
    fsum = {1'b0, pc} + (AW+1)'(cmd.fetch_idx);
    faddr = (fsum >= (AW+1)'(svm_pkg::MEM_WORDS))
          ? AW'(fsum - (AW+1)'(svm_pkg::MEM_WORDS)) : AW'(fsum);
  end

  assign add_sum = {1'b0, v2} + {1'b0, v3};
  assign prod    = 32'(v2) * 32'(v3);

  // instruction execute
  always_comb begin
    err = svm_pkg::STAT_OK;
    reg_we = 1'b0; reg_wd = '0;
    push = 1'b0; push_d = '0; pop = 1'b0;
    mem_wr = 1'b0; out_v = 1'b0; in_u = 1'b0;
    need_mem = 1'b0; need_stk = 1'b0; need_div = 1'b0;
    new_pc = npc;
    take = (op == svm_pkg::OP_JT) == (v1 != 16'd0);
    if (op_bad) begin
      err = svm_pkg::STAT_BADOP;
    end else begin
      case (op)
        svm_pkg::OP_HALT: err = svm_pkg::STAT_HALT;
        svm_pkg::OP_SET, svm_pkg::OP_NOT: begin
          if (!(d1ok && ok2)) err = svm_pkg::STAT_BADARG;
          else begin
            reg_we = 1'b1;
            reg_wd = (op == svm_pkg::OP_SET) ? v2 : {1'b0, ~v2[14:0]};
          end
        end
        svm_pkg::OP_PUSH: begin
          if (!ok1) err = svm_pkg::STAT_BADARG;
          else if (sp_full) err = svm_pkg::STAT_OVFL;
          else begin
            push = 1'b1; push_d = v1;
          end
        end
        svm_pkg::OP_POP: begin
          if (!d1ok) err = svm_pkg::STAT_BADARG;
          else if (sp_empty) err = svm_pkg::STAT_EMPTY;
          else begin
            need_stk = 1'b1; pop = 1'b1; reg_we = 1'b1; reg_wd = stk_rdata;
          end
        end
        svm_pkg::OP_EQ, svm_pkg::OP_GT, svm_pkg::OP_ADD, svm_pkg::OP_MULT,
        svm_pkg::OP_MOD, svm_pkg::OP_AND, svm_pkg::OP_OR: begin
          if (!(d1ok && ok2 && ok3)) err = svm_pkg::STAT_BADARG;
          else begin
            reg_we = 1'b1;
            unique case (op)
              svm_pkg::OP_EQ:   reg_wd = {15'd0, v2 == v3};
              svm_pkg::OP_GT:   reg_wd = {15'd0, v2 > v3};
              svm_pkg::OP_ADD:  reg_wd = {1'b0, add_sum[14:0]};
              svm_pkg::OP_MULT: reg_wd = {1'b0, prod[14:0]};
              svm_pkg::OP_AND:  reg_wd = v2 & v3;
              svm_pkg::OP_OR:   reg_wd = v2 | v3;
              default: begin
                if (v3 == 16'd0) begin
                  err = svm_pkg::STAT_DIV0; reg_we = 1'b0;
                end else begin
                  need_div = 1'b1; reg_wd = div_rem;
                end
              end
            endcase
          end
        end
        svm_pkg::OP_JMP, svm_pkg::OP_CALL: begin
          if (!ok1 || !svm_pkg::addr_ok(v1)) err = svm_pkg::STAT_BADARG;
          else if (op == svm_pkg::OP_CALL && sp_full) err = svm_pkg::STAT_OVFL;
          else begin
            push   = op == svm_pkg::OP_CALL;
            push_d = 16'(npc);
            new_pc = v1[AW-1:0];
          end
        end
        svm_pkg::OP_JT, svm_pkg::OP_JF: begin
          if (!(ok1 && ok2)) err = svm_pkg::STAT_BADARG;
          else if (take) begin
            if (!svm_pkg::addr_ok(v2)) err = svm_pkg::STAT_BADARG;
            else new_pc = v2[AW-1:0];
          end
        end
        svm_pkg::OP_RMEM: begin
          if (!(d1ok && ok2) || !svm_pkg::addr_ok(v2)) err = svm_pkg::STAT_BADARG;
          else begin
            need_mem = 1'b1; reg_we = 1'b1; reg_wd = mem_rdata;
          end
        end
        svm_pkg::OP_WMEM: begin
          if (!(ok1 && ok2) || !svm_pkg::addr_ok(v1)) err = svm_pkg::STAT_BADARG;
          else mem_wr = 1'b1;
        end
        svm_pkg::OP_RET: begin
          if (sp_empty) err = svm_pkg::STAT_EMPTY;
          else begin
            need_stk = 1'b1;
            if (!svm_pkg::addr_ok(stk_rdata)) err = svm_pkg::STAT_BADARG;
            else begin
              pop = 1'b1; new_pc = stk_rdata[AW-1:0];
            end
          end
        end
        svm_pkg::OP_OUT: begin
          if (!ok1) err = svm_pkg::STAT_BADARG;
          else out_v = 1'b1;
        end
        svm_pkg::OP_IN: begin
          if (!d1ok) err = svm_pkg::STAT_BADARG;
          else begin
            reg_we = 1'b1; reg_wd = {8'd0, ch}; in_u = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign exec_ok = cmd.commit && run && (err == svm_pkg::STAT_OK);
  assign load_wr = !kind && (32'(laddr) < svm_pkg::MEM_WORDS);

  // program memory port select
  always_comb begin
    mem_we = 1'b0; mem_waddr = clr_cnt[AW-1:0]; mem_wdata = '0;
    if (cmd.clear) begin
      mem_we = 1'b1;
    end else if (cmd.commit) begin
      mem_we    = run ? (exec_ok && mem_wr) : load_wr;
      mem_waddr = run ? v1[AW-1:0] : laddr[AW-1:0];
      mem_wdata = run ? v2 : lword;
    end
    mem_re    = cmd.fetch || (cmd.rd_issue && need_mem);
    mem_raddr = cmd.fetch ? faddr : v2[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata <= mem[mem_raddr];
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (exec_ok && push) stack[sp[SAW-1:0]] <= push_d;
    if (cmd.rd_issue) stk_rdata <= stack[sp_m1[SAW-1:0]];
  end

  // item and instruction word capture
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind  <= s_tuser;
      laddr <= s_tdata[14:0];
      lword <= s_tdata[30:15];
      ch    <= s_tdata[38:31];
    end
    if (cmd.cap) w[cmd.cap_idx] <= mem_rdata;
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= '0;
      sp      <= '0;
      stopped <= svm_pkg::STAT_OK;
      clr_cnt <= '0;
      for (int i = 0; i < svm_pkg::NUM_REGS; i++) regs[i] <= '0;
    end else begin
      if (cmd.clear) clr_cnt <= clr_cnt + (AW+1)'(1);
      if (cmd.commit && run && (err != svm_pkg::STAT_OK)) stopped <= err;
      if (exec_ok) begin
        pc <= new_pc;
        if (reg_we) regs[w[1][svm_pkg::REG_AW-1:0]] <= reg_wd;
        if (push) sp <= sp + SPW'(1);
        else if (pop) sp <= sp_m1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      r_status    <= run ? err : stopped;
      r_out_valid <= exec_ok && out_v;
      r_out_char  <= (exec_ok && out_v) ? v1[7:0] : 8'd0;
      r_in_used   <= exec_ok && in_u;
      r_next_pc   <= exec_ok ? 15'(new_pc) : 15'(pc);
    end
  end

  assign m_tdata = {4'd0, r_next_pc, r_in_used, r_out_char, r_out_valid, r_status};

  svm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (v2),
    .divisor  (v3),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  always_comb begin
    sts.clear_done = clr_cnt == (AW+1)'(svm_pkg::MEM_WORDS);
    sts.run        = run;
    sts.need_mem   = need_mem;
    sts.need_stk   = need_stk;
    sts.need_div   = need_div;
    sts.div_busy   = div_busy;
    sts.out_free   = out_free;
  end

  `SVM_ASSERT(a_sp_bound, clk, rst, sp <= SPW'(svm_pkg::STACK_DEPTH), "stack pointer past depth")
  `SVM_ASSERT(a_stop_sticky, clk, rst, (stopped != svm_pkg::STAT_OK) |=> (stopped == $past(stopped)), "stop code changed")
  `SVM_ASSERT(a_commit_free, clk, rst, cmd.commit |-> out_free, "result overwritten")
  `SVM_ASSERT(a_pc_hold, clk, rst, !cmd.commit |=> $stable(pc), "pc moved without commit")
  `SVM_ASSERT_NEVER(a_clear_busy, clk, rst, cmd.clear && (cmd.commit || cmd.fetch), "access during clear")
endmodule
`default_nettype wire

### hw/rtl/svm_ctrl.sv
// ---------------------------------------------------------------------------
// svm_ctrl
// Sequencer: memory clear, word fetch, operand read, divide wait, commit.
// ---------------------------------------------------------------------------
`default_nettype none
module svm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire svm_pkg::sts_t sts,
  output svm_pkg::cmd_t      cmd
);
  svm_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svm_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      svm_pkg::S_CLEAR: begin
        cmd.clear = !sts.clear_done;
        if (sts.clear_done) state_next = svm_pkg::S_IDLE;
      end
      svm_pkg::S_IDLE: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
        if (s_tvalid) state_next = svm_pkg::S_F0;
      end
      svm_pkg::S_F0: begin
        if (!sts.run) begin
          state_next = svm_pkg::S_COMMIT;
        end else begin
          cmd.fetch = 1'b1; cmd.fetch_idx = 2'd0;
          state_next = svm_pkg::S_F1;
        end
      end
      svm_pkg::S_F1: begin
        cmd.cap = 1'b1; cmd.cap_idx = 2'd0;
        cmd.fetch = 1'b1; cmd.fetch_idx = 2'd1;
        state_next = svm_pkg::S_F2;
      end
      svm_pkg::S_F2: begin
        cmd.cap = 1'b1; cmd.cap_idx = 2'd1;
        cmd.fetch = 1'b1; cmd.fetch_idx = 2'd2;
        state_next = svm_pkg::S_F3;
      end
      svm_pkg::S_F3: begin
        cmd.cap = 1'b1; cmd.cap_idx = 2'd2;
        cmd.fetch = 1'b1; cmd.fetch_idx = 2'd3;
        state_next = svm_pkg::S_F4;
      end
      svm_pkg::S_F4: begin
        cmd.cap = 1'b1; cmd.cap_idx = 2'd3;
        state_next = svm_pkg::S_EVAL;
      end
      svm_pkg::S_EVAL: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_next = svm_pkg::S_DIV;
        end else begin
          cmd.rd_issue = sts.need_mem || sts.need_stk;
          state_next = svm_pkg::S_COMMIT;
        end
      end
      svm_pkg::S_DIV: begin
        if (!sts.div_busy) state_next = svm_pkg::S_COMMIT;
      end
      svm_pkg::S_COMMIT: begin
        cmd.commit = sts.out_free;
        if (sts.out_free) state_next = svm_pkg::S_IDLE;
      end
      default: state_next = svm_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### hw/rtl/stack_vm_sixteen_bit_core.sv
// Sequence: a load word or a step on a stopped core passes S_IDLE, S_F0 and S_COMMIT;
// a step passes S_IDLE, S_F0 to S_F4 (four single-port memory fetches), S_EVAL (decode)
// and S_COMMIT, and a mod step also waits in S_DIV for the one-bit-per-cycle divider.
// A new word is accepted only in S_IDLE, once the last has committed; a full output
// register stalls commit. Reset: synchronous; afterwards the core clears program memory
// one word per cycle for all MEM_WORDS words and accepts no word until that pass ends.
// ---------------------------------------------------------------------------
// stack_vm_sixteen_bit_core
// Sixteen-bit stack machine: controller plus datapath on stream ports.
// ---------------------------------------------------------------------------
`default_nettype none
module stack_vm_sixteen_bit_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // load_addr[14:0], load_word[30:15], in_char[38:31]
  input  wire logic        s_tuser,  // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata   // status[2:0], out_valid[3], out_char[11:4],
                                     // in_used[12], next_pc[27:13]
);
  svm_pkg::cmd_t cmd;
  svm_pkg::sts_t sts;

  svm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  svm_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );
endmodule
`default_nettype wire
